// ===== sv/lpe_pkg.sv =====
// LED pattern engine package: pattern codes, command codes, register indexes,
// reset values and the item and result payload types.
// No dependencies.
package lpe_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int NOW_W         = 32;
	localparam int PERIOD_W      = 16;

	typedef enum logic [2:0] {
		PAT_OFF  = 3'd0,
		PAT_ON   = 3'd1,
		PAT_SLOW = 3'd2,
		PAT_FAST = 3'd3,
		PAT_BEAT = 3'd4
	} pattern_t;

	typedef enum logic {
		CMD_UPDATE = 1'b0,
		CMD_CHANGE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SLOW_PERIOD = 2'd0,
		REG_FAST_PERIOD = 2'd1,
		REG_BEAT_SHORT  = 2'd2,
		REG_BEAT_PAUSE  = 2'd3
	} reg_index_t;

	localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 16'd500;
	localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 16'd100;
	localparam logic [PERIOD_W-1:0] BEAT_SHORT_RST  = 16'd100;
	localparam logic [PERIOD_W-1:0] BEAT_PAUSE_RST  = 16'd600;

	localparam logic [1:0] PHASE_PAUSE = 2'd3;

	typedef struct packed {
		logic             cmd;
		logic [2:0]       pattern;
		logic [NOW_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic       led_lit;
		logic [2:0] active_pattern;
		logic [1:0] beat_phase;
	} result_t;

endpackage

// ===== sv/lpe_if.sv =====
// Stream interfaces for the LED pattern engine: item channel and result channel.
// Depends on lpe_pkg.
interface lpe_item_if;
	import lpe_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lpe_result_if;
	import lpe_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/led_pattern_engine.sv =====
// LED pattern engine top level: input register, next-state logic, result register.
// Depends on lpe_pkg and the stream interfaces in lpe_if.sv.
//
//   channel   | dir | handshake        | payload
//   ----------+-----+------------------+-------------------------------------
//   items     | in  | valid / ready    | cmd, pattern, now_ms
//   results   | out | valid / ready    | led_lit, active_pattern, beat_phase
//   cfg       | in  | cfg_we only      | cfg_index (2b), cfg_wdata (16b)
//
// The input register takes the item at its transfer; the update logic then loads
// the result register, which drives results.valid, as soon as the result slot is
// free or leaving. One item per cycle sustained while results.ready stays high;
// the only path is one TIME_BITS subtract and compare. Reset clears mode, phase,
// LED and timer and loads the period defaults; no sweep. A stalled result holds
// the result register; the input register still drains into it on the same edge
// the result transfers, so no bubble under ready.
module led_pattern_engine #(
	parameter int TIME_BITS = lpe_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lpe_item_if.sink                      items,
	lpe_result_if.source                  results,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [lpe_pkg::PERIOD_W-1:0]  cfg_wdata
);
	import lpe_pkg::*;

	// period registers
	logic [PERIOD_W-1:0] slow_period_q, fast_period_q, beat_short_q, beat_pause_q;

	// input stage
	logic  s1_valid;
	item_t s1_item;

	// engine state
	pattern_t             mode_q;
	logic [TIME_BITS-1:0] last_toggle_q;
	logic                 lit_q;
	logic [1:0]           phase_q;

	// result stage
	logic    res_valid_q;
	result_t res_q;

	// next-state terms
	pattern_t             mode_d;
	logic [TIME_BITS-1:0] last_toggle_d;
	logic                 lit_d;
	logic [1:0]           phase_d;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic [PERIOD_W-1:0]  period;
	logic                 expired;
	logic [1:0]           phase_inc;
	logic                 advance;

	// s1 moves into the result register when the result slot is free or leaving
	assign advance       = s1_valid && (!res_valid_q || results.ready);
	assign items.ready   = !s1_valid || advance;
	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_period_q <= SLOW_PERIOD_RST;
			fast_period_q <= FAST_PERIOD_RST;
			beat_short_q  <= BEAT_SHORT_RST;
			beat_pause_q  <= BEAT_PAUSE_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SLOW_PERIOD: slow_period_q <= cfg_wdata;
				REG_FAST_PERIOD: fast_period_q <= cfg_wdata;
				REG_BEAT_SHORT:  beat_short_q  <= cfg_wdata;
				REG_BEAT_PAUSE:  beat_pause_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (items.ready) begin
			s1_valid <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			s1_item <= items.data;
		end
	end

	// timestamp taken modulo 2^TIME_BITS; elapsed wraps the same way
	assign now_t   = TIME_BITS'(s1_item.now_ms);
	assign elapsed = now_t - last_toggle_q;

	always_comb begin
		case (mode_q)
			PAT_SLOW: period = slow_period_q;
			PAT_FAST: period = fast_period_q;
			default:  period = (phase_q == PHASE_PAUSE) ? beat_pause_q : beat_short_q;
		endcase
	end

	assign expired   = elapsed >= TIME_BITS'(period);
	assign phase_inc = phase_q + 2'd1;

	always_comb begin
		mode_d        = mode_q;
		last_toggle_d = last_toggle_q;
		lit_d         = lit_q;
		phase_d       = phase_q;
		if (cmd_t'(s1_item.cmd) == CMD_CHANGE) begin
			// undefined codes and a repeat of the current pattern change nothing
			if (s1_item.pattern <= PAT_BEAT && s1_item.pattern != mode_q) begin
				mode_d        = pattern_t'(s1_item.pattern);
				last_toggle_d = now_t;
				phase_d       = 2'd0;
				lit_d         = (s1_item.pattern == PAT_ON);
			end
		end else begin
			case (mode_q)
				PAT_SLOW, PAT_FAST: begin
					if (expired) begin
						lit_d         = !lit_q;
						last_toggle_d = now_t;
					end
				end
				PAT_BEAT: begin
					// even phases lit, odd phases dark
					if (expired) begin
						phase_d       = phase_inc;
						lit_d         = !phase_inc[0];
						last_toggle_d = now_t;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= PAT_OFF;
			last_toggle_q <= '0;
			lit_q         <= 1'b0;
			phase_q       <= 2'd0;
			res_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				mode_q        <= mode_d;
				last_toggle_q <= last_toggle_d;
				lit_q         <= lit_d;
				phase_q       <= phase_d;
				res_valid_q   <= 1'b1;
			end else if (results.ready) begin
				res_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.led_lit        <= lit_d;
			res_q.active_pattern <= mode_d;
			res_q.beat_phase     <= phase_d;
		end
	end

endmodule

// ===== sv/lpe_checker.sv =====
// Port-level checks for the LED pattern engine, bound to the top level.
// Depends on lpe_pkg and led_pattern_engine.
module lpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       led_lit,
	input logic [2:0] active_pattern,
	input logic [1:0] beat_phase
);
	import lpe_pkg::*;

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable({led_lit, active_pattern, beat_phase}))
		else $error("result changed while stalled");

	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && active_pattern == PAT_OFF |-> !led_lit)
		else $error("LED lit in off pattern");

	a_on_lit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && active_pattern == PAT_ON |-> led_lit)
		else $error("LED dark in on pattern");

	a_phase_beat_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && active_pattern != PAT_BEAT |-> beat_phase == 2'd0)
		else $error("heartbeat phase nonzero outside heartbeat");

endmodule

bind led_pattern_engine lpe_checker u_lpe_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (results.valid),
	.res_ready      (results.ready),
	.led_lit        (results.data.led_lit),
	.active_pattern (results.data.active_pattern),
	.beat_phase     (results.data.beat_phase)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for led_pattern_engine: directed and random pattern/update items.
// Depends on lpe_pkg, lpe_item_if / lpe_result_if and the led_pattern_engine RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lpe_pkg::*;

	// Watchdog: cycles in a row without any transfer on either channel.
	// Worst legit quiet stretch is the long receiver hold-off (HOLD_CYCLES)
	// plus a few idle cycles around register writes.
	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 4;   // input and result registers plus margin

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	lpe_item_if   items ();
	lpe_result_if results ();

	led_pattern_engine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.results  (results),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Traffic shaping knobs, changed by the test tasks between phases.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_len       = 0;
	int hold_id        = 0;
	int errors         = 0;

	// Predicted LED state, kept in step with every accepted item.
	pattern_t    led_mode;
	logic [31:0] led_mark;     // timestamp of last toggle / phase or pattern change
	logic        led_on;
	logic [1:0]  led_phase;
	logic [15:0] period_reg [4];

	// Millisecond wall clock that the stimulus walks forward.
	logic [31:0] wall_ms;

	result_t pending_led [$];

	task automatic reset_led_model();
		led_mode  = PAT_OFF;
		led_mark  = '0;
		led_on    = 1'b0;
		led_phase = '0;
		period_reg[REG_SLOW_PERIOD] = SLOW_PERIOD_RST;
		period_reg[REG_FAST_PERIOD] = FAST_PERIOD_RST;
		period_reg[REG_BEAT_SHORT]  = BEAT_SHORT_RST;
		period_reg[REG_BEAT_PAUSE]  = BEAT_PAUSE_RST;
		wall_ms = '0;
	endtask

	// Current interval the engine is timing against; off/on have none.
	function automatic logic [31:0] span_now();
		case (led_mode)
			PAT_SLOW: return 32'(period_reg[REG_SLOW_PERIOD]);
			PAT_FAST: return 32'(period_reg[REG_FAST_PERIOD]);
			PAT_BEAT: return (led_phase == PHASE_PAUSE) ? 32'(period_reg[REG_BEAT_PAUSE])
			                                            : 32'(period_reg[REG_BEAT_SHORT]);
			default:  return 32'd50;
		endcase
	endfunction

	// Next LED state for one accepted item; updates the predicted state.
	function automatic result_t led_next(input item_t it);
		logic [31:0] elapsed;
		result_t     r;
		elapsed = it.now_ms - led_mark;   // wraps mod 2^32
		if (it.cmd == CMD_CHANGE) begin
			// Unknown codes and a request for the running pattern change nothing.
			if (it.pattern <= PAT_BEAT && it.pattern != led_mode) begin
				led_mode  = pattern_t'(it.pattern);
				led_mark  = it.now_ms;
				led_phase = '0;
				led_on    = (it.pattern == PAT_ON);
			end
		end else if (led_mode == PAT_SLOW || led_mode == PAT_FAST) begin
			if (elapsed >= span_now()) begin
				led_on   = ~led_on;
				led_mark = it.now_ms;
			end
		end else if (led_mode == PAT_BEAT) begin
			if (elapsed >= span_now()) begin
				led_phase = led_phase + 2'd1;
				// Phases 0 and 2 are the lit beats; first pass through 0 stays dark.
				led_on    = (led_phase == 2'd0 || led_phase == 2'd2);
				led_mark  = it.now_ms;
			end
		end
		r.led_lit        = led_on;
		r.active_pattern = led_mode;
		r.beat_phase     = led_phase;
		return r;
	endfunction

	// Offer one item, honoring the sender idle rate; returns after its transfer.
	// valid is only lowered while idling, so back-to-back items keep it high.
	task automatic send_item(input item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid <= 1'b1;
		items.data  <= it;
		do @(posedge clk); while (!items.ready);
		pending_led.push_back(led_next(it));
	endtask

	task automatic send_at(input cmd_t c, input logic [2:0] pat, input logic [31:0] t);
		item_t it;
		wall_ms    = t;
		it.cmd     = c;
		it.pattern = pat;
		it.now_ms  = t;
		send_item(it);
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic drain();
		items.valid <= 1'b0;
		while (pending_led.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Registers are only touched with the engine empty; the caller drops cfg_we.
	task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		period_reg[idx] = val;
	endtask

	task automatic write_all(input logic [15:0] slow, input logic [15:0] fast,
	                         input logic [15:0] beat, input logic [15:0] pause);
		drain();
		write_reg(REG_SLOW_PERIOD, slow);
		write_reg(REG_FAST_PERIOD, fast);
		write_reg(REG_BEAT_SHORT, beat);
		write_reg(REG_BEAT_PAUSE, pause);
		cfg_we <= 1'b0;
	endtask

	// Mostly short periods so the modes cycle often; the extremes now and then.
	function automatic logic [15:0] pick_period();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)       return 16'd0;
		else if (roll < 10) return 16'd1;
		else if (roll < 17) return 16'hFFFF;
		else if (roll < 55) return 16'($urandom_range(1, 20));
		else if (roll < 85) return 16'($urandom_range(1, 1000));
		else                return 16'($urandom_range(1, 65535));
	endfunction

	// Time advance aimed at the edges of the running interval.
	function automatic logic [31:0] pick_step();
		logic [31:0] span;
		logic [31:0] spent;
		logic [31:0] left;
		span  = span_now();
		spent = wall_ms - led_mark;
		left  = (spent < span) ? span - spent : 32'd0;
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return (left == 0) ? 32'd0 : left - 32'd1;
			2, 3:    return left;
			4:       return left + 32'd1;
			5:       return $urandom_range(0, span + span);
			default: return $urandom_range(0, left);
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	// Hand-picked sequence at reset periods: every pattern, the ignored
	// requests, exact interval edges and a heartbeat cycle across the wrap.
	task automatic test_directed();
		send_at(CMD_UPDATE, 3'd7, 32'd0);            // off after reset, pattern ignored
		send_at(CMD_CHANGE, PAT_ON, 32'd10);         // lit at once
		send_at(CMD_CHANGE, PAT_ON, 32'd20);         // same pattern: no restart
		send_at(CMD_CHANGE, 3'd5, 32'd30);           // undefined codes ignored
		send_at(CMD_CHANGE, 3'd6, 32'd31);
		send_at(CMD_CHANGE, 3'd7, 32'd32);
		send_at(CMD_CHANGE, PAT_SLOW, 32'd100);      // starts dark
		send_at(CMD_UPDATE, PAT_OFF, 32'd599);       // one short of the period
		send_at(CMD_UPDATE, PAT_OFF, 32'd600);       // exactly the period: toggle
		send_at(CMD_CHANGE, PAT_FAST, 32'd700);
		send_at(CMD_UPDATE, PAT_BEAT, 32'd799);
		send_at(CMD_UPDATE, PAT_BEAT, 32'd800);
		// Heartbeat started just below the wrap; first beat stays dark.
		send_at(CMD_CHANGE, PAT_BEAT, 32'hFFFF_FFC0);
		send_at(CMD_UPDATE, PAT_OFF, 32'hFFFF_FFC0 + 32'd99);
		send_at(CMD_UPDATE, PAT_OFF, 32'hFFFF_FFC0 + 32'd100);  // wraps to 0x24
		send_at(CMD_UPDATE, PAT_OFF, 32'h24 + 32'd100);
		send_at(CMD_UPDATE, PAT_OFF, 32'h24 + 32'd200);         // into the pause
		send_at(CMD_UPDATE, PAT_OFF, 32'h24 + 32'd799);
		send_at(CMD_UPDATE, PAT_OFF, 32'h24 + 32'd800);         // back to phase 0, lit
		send_at(CMD_CHANGE, PAT_OFF, 32'hFFFF_FFFF);
		drain();
	endtask

	// Zero periods make every update fire; all-ones periods almost never.
	task automatic test_period_extremes();
		write_all(16'd0, 16'd0, 16'd0, 16'd0);
		send_at(CMD_CHANGE, PAT_SLOW, 32'd5000);
		send_at(CMD_UPDATE, PAT_SLOW, 32'd5000);
		send_at(CMD_UPDATE, PAT_SLOW, 32'd5000);
		send_at(CMD_CHANGE, PAT_BEAT, 32'd5000);
		repeat (5) send_at(CMD_UPDATE, PAT_BEAT, 32'd5000);
		send_at(CMD_CHANGE, PAT_FAST, 32'd6000);
		send_at(CMD_UPDATE, PAT_FAST, 32'd6000);
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_at(CMD_CHANGE, PAT_SLOW, 32'd0);
		send_at(CMD_UPDATE, PAT_SLOW, 32'd65534);
		send_at(CMD_UPDATE, PAT_SLOW, 32'd65535);
		send_at(CMD_CHANGE, PAT_BEAT, 32'd70000);
		send_at(CMD_UPDATE, PAT_BEAT, 32'd70000 + 32'd65535);
		send_at(CMD_CHANGE, PAT_OFF, 32'd200000);
		write_all(16'd1, 16'd1, 16'd1, 16'd1);
		send_at(CMD_CHANGE, PAT_FAST, 32'd300);
		send_at(CMD_UPDATE, PAT_FAST, 32'd300);
		send_at(CMD_UPDATE, PAT_FAST, 32'd301);
		drain();
	endtask

	// Receiver shuts off for a long stretch while items keep coming, so the
	// engine's two registers fill and items.ready must drop.
	task automatic test_backpressure();
		int k;
		item_t it;
		drain();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_len <= HOLD_CYCLES;
		hold_id  <= hold_id + 1;
		send_at(CMD_CHANGE, PAT_FAST, wall_ms);
		for (k = 0; k < 40; k++) begin
			wall_ms    = wall_ms + pick_step();
			it.cmd     = CMD_UPDATE;
			it.pattern = 3'($urandom_range(0, 7));
			it.now_ms  = wall_ms;
			send_item(it);
		end
		drain();
	endtask

	// Random traffic: mostly updates timed against the running interval,
	// some pattern requests (valid, repeated and undefined), jumps and wraps.
	task automatic run_random(input int count);
		int    k;
		int    roll;
		item_t it;
		for (k = 0; k < count; k++) begin
			roll       = $urandom_range(0, 99);
			it.cmd     = CMD_UPDATE;
			it.pattern = 3'($urandom_range(0, 7));
			if (roll < 10) begin
				it.cmd     = CMD_CHANGE;
				it.pattern = 3'($urandom_range(0, 4));
				wall_ms    = wall_ms + $urandom_range(0, 3);
			end else if (roll < 12) begin
				it.cmd  = CMD_CHANGE;
				wall_ms = wall_ms + $urandom_range(0, 3);
			end else if (roll < 15) begin
				wall_ms = $urandom();
			end else if (roll < 17) begin
				wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
			end else begin
				wall_ms = wall_ms + pick_step();
			end
			it.now_ms = wall_ms;
			send_item(it);
		end
	endtask

	task automatic test_random();
		int ph;
		int c;
		int idle_set  [4] = '{0, 46, 0, 35};
		int stall_set [4] = '{0, 0, 46, 35};
		for (ph = 0; ph < 4; ph++) begin
			for (c = 0; c < 3; c++) begin
				write_all(pick_period(), pick_period(), pick_period(), pick_period());
				send_idle_pct  = idle_set[ph];
				recv_stall_pct = stall_set[ph];
				run_random(160);
			end
		end
		drain();
	endtask

	// ----------------------------------------------------------- processes

	// Result sink: random stalls, the long hold-off, and the check of every
	// transfer against the oldest prediction.
	initial begin : result_sink
		int      hold_left;
		int      hold_seen;
		result_t want;
		result_t got;
		hold_left = 0;
		hold_seen = 0;
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results.valid && results.ready) begin
				got = results.data;
				if (pending_led.size() == 0) begin
					errors++;
					$display("%0t: result with nothing pending, got %p", $time, got);
				end else begin
					want = pending_led.pop_front();
					if (got.led_lit !== want.led_lit) begin
						errors++;
						$display("%0t: led_lit expected %0b got %0b",
						         $time, want.led_lit, got.led_lit);
					end
					if (got.active_pattern !== want.active_pattern) begin
						errors++;
						$display("%0t: active_pattern expected %0d got %0d",
						         $time, want.active_pattern, got.active_pattern);
					end
					if (got.beat_phase !== want.beat_phase) begin
						errors++;
						$display("%0t: beat_phase expected %0d got %0d",
						         $time, want.beat_phase, got.beat_phase);
					end
				end
			end
			if (hold_id != hold_seen) begin
				hold_seen = hold_id;
				hold_left = hold_len;
			end
			if (!arst_n) begin
				results.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else begin
				results.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog on quiet cycles; reset time does not count.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (arst_n && !((items.valid && items.ready) || (results.valid && results.ready)))
				quiet++;
			else
				quiet = 0;
			if (quiet >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Main sequence: reset once, then each test in turn.
	initial begin : main_seq
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_SLOW_PERIOD;
		cfg_wdata   <= '0;
		items.valid <= 1'b0;
		items.data  <= '0;
		reset_led_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_period_extremes();
		test_backpressure();
		test_random();

		// Everything has drained; give the pipe a few more cycles for strays.
		repeat (10) @(posedge clk);
		if (pending_led.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_led.size());
		end
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/lpe_pkg.sv
sv/lpe_if.sv
sv/led_pattern_engine.sv
sv/lpe_checker.sv
tb/tb_top.sv
